[hw/rtl/i2a_pkg.sv]
// i2a_pkg: shared types and constants for the integer to ASCII converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2a_pkg;

   localparam int VALUE_W    = 64;
   localparam int BCD_DIGITS = 20;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int IDX_W      = $clog2(BCD_DIGITS);
   localparam int CONV_STEPS = 16;
   localparam int BITS_STEP  = VALUE_W / CONV_STEPS;
   localparam int CNT_W      = $clog2(CONV_STEPS);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [127:0] DIGIT_CHARS = "0123456789abcdef";
   localparam logic [7:0]   CHAR_ZERO   = "0";
   localparam logic [7:0]   CHAR_X      = "x";

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ZERO = 2'd0;
   localparam kind_type KIND_DEC  = 2'd1;
   localparam kind_type KIND_HEX  = 2'd2;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               func;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      kind_type           kind;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_port_type;

endpackage

`default_nettype wire

[hw/rtl/integer_to_ascii_decimal_hex_unit.sv]
// integer_to_ascii_decimal_hex_unit: 64-bit value to ASCII decimal or 0x-hex.
// Depends on i2a_pkg, i2a_front, i2a_queue, i2a_back.
// Back end per item: decimal pops, runs double-dabble, searches the leading digit and
// emits the digits; hex pops, searches, emits "0x" and the digits; zero pops and emits "0".
// One character per cycle on rsp unless rsp_ready stalls it; a 2-entry queue decouples req.
// Synchronous active-high reset empties the queue and drops pending output.
`default_nettype none

module integer_to_ascii_decimal_hex_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire i2a_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output i2a_pkg::rsp_type      rsp_data
);
   import i2a_pkg::*;

   q_port_type q_wr;
   q_port_type q_rd;
   logic       q_ready;
   logic       q_pop;

   i2a_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_wr      (q_wr),
      .q_ready   (q_ready)
   );

   i2a_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_wr    (q_wr),
      .q_ready (q_ready),
      .q_rd    (q_rd),
      .q_pop   (q_pop)
   );

   i2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_rd      (q_rd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_rd.valid)
      else $error("queue popped while empty");

   a_zero_kind_ok: assert property (@(posedge clock) disable iff (reset)
      q_wr.valid |-> ((q_wr.entry.kind == KIND_ZERO) == (q_wr.entry.value == '0)))
      else $error("zero classification mismatch");

   a_no_output_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_prefix_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.char_out == CHAR_X) |-> !rsp_data.last)
      else $error("hex prefix marked as last transfer");

endmodule

`default_nettype wire

[hw/rtl/i2a_front.sv]
// i2a_front: input stage; registers each transfer and classifies it as zero,
// decimal or hex before pushing it to the queue. Depends on i2a_pkg.
`default_nettype none

module i2a_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire i2a_pkg::req_type req_data,
   output i2a_pkg::q_port_type   q_wr,
   input  wire logic             q_ready
);
   import i2a_pkg::*;

   logic      hold_valid_ff, hold_valid_in;
   entry_type hold_ff, hold_in;
   logic      take;

   assign req_ready = !hold_valid_ff || q_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      hold_in = hold_ff;
      hold_valid_in = hold_valid_ff && !q_ready;
      if (take) begin
         hold_valid_in = 1'b1;
         hold_in.value = req_data.value;
         if (req_data.value == '0) begin
            hold_in.kind = KIND_ZERO;
         end else if (req_data.func) begin
            hold_in.kind = KIND_HEX;
         end else begin
            hold_in.kind = KIND_DEC;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

   assign q_wr.valid = hold_valid_ff;
   assign q_wr.entry = hold_ff;

endmodule

`default_nettype wire

[hw/rtl/i2a_queue.sv]
// i2a_queue: two-entry queue between front and back of the converter.
// Depends on i2a_pkg.
`default_nettype none

module i2a_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire i2a_pkg::q_port_type  q_wr,
   output logic                      q_ready,
   output i2a_pkg::q_port_type       q_rd,
   input  wire logic                 q_pop
);
   import i2a_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]        count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign q_ready = (count_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign push    = q_wr.valid && q_ready;
   assign pop     = q_pop && (count_ff != '0);

   assign q_rd.valid = (count_ff != '0);
   assign q_rd.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= q_wr.entry;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/i2a_back.sv]
// i2a_back: conversion engine; decimal double-dabble at four bits per cycle, leading
// digit search, then one character per transfer. Depends on i2a_pkg.
`default_nettype none

module i2a_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire i2a_pkg::q_port_type q_rd,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output i2a_pkg::rsp_type         rsp_data
);
   import i2a_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_FIND = 3'd2;
   localparam logic [2:0] ST_PFX0 = 3'd3;
   localparam logic [2:0] ST_PFXX = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic bit_in);
      logic [BCD_W-1:0] r;
      logic [3:0]       d;
      r = '0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         d = bcd[i*4 +: 4];
         if (d >= 4'd5) begin
            d = d + 4'd3;
         end
         r[i*4 +: 4] = d;
      end
      return {r[BCD_W-2:0], bit_in};
   endfunction

   function automatic logic [IDX_W-1:0] msd_index(input logic [BCD_W-1:0] bcd);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd[i*4 +: 4] != 4'd0) begin
            r = IDX_W'(i);
         end
      end
      return r;
   endfunction

   logic [2:0]         state_ff, state_in;
   logic [BCD_W-1:0]   dig_ff, dig_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               hex_ff, hex_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               out_free;
   logic [BCD_W-1:0]   conv_bcd;
   logic [VALUE_W-1:0] conv_val;
   logic [3:0]         cur_digit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cur_digit = dig_ff[idx_ff*4 +: 4];

   always_comb begin
      conv_bcd = dig_ff;
      conv_val = val_ff;
      for (int k = 0; k < BITS_STEP; k++) begin
         conv_bcd = dd_step(conv_bcd, conv_val[VALUE_W-1]);
         conv_val = {conv_val[VALUE_W-2:0], 1'b0};
      end
   end

   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      hex_in       = hex_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_rd.valid) begin
               q_pop  = 1'b1;
               hex_in = (q_rd.entry.kind == KIND_HEX);
               unique case (q_rd.entry.kind)
                  KIND_HEX: begin
                     dig_in   = BCD_W'(q_rd.entry.value);
                     state_in = ST_FIND;
                  end
                  KIND_DEC: begin
                     dig_in   = '0;
                     val_in   = q_rd.entry.value;
                     cnt_in   = '1;
                     state_in = ST_CONV;
                  end
                  default: begin
                     dig_in   = '0;
                     idx_in   = '0;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_CONV: begin
            dig_in = conv_bcd;
            val_in = conv_val;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            idx_in   = msd_index(dig_ff);
            state_in = hex_ff ? ST_PFX0 : ST_EMIT;
         end
         ST_PFX0: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.char_out = CHAR_ZERO;
               rsp_in.last     = 1'b0;
               state_in        = ST_PFXX;
            end
         end
         ST_PFXX: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.char_out = CHAR_X;
               rsp_in.last     = 1'b0;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.char_out = DIGIT_CHARS[(4'd15 - cur_digit)*8 +: 8];
               rsp_in.last     = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dig_ff <= dig_in;
      val_ff <= val_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      hex_ff <= hex_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
